### rtl/arh_pkg.sv
// ----------------------------------------------------------------------------
// arh_pkg
// Shared types and codes for the ray / axis-aligned rectangle hit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package arh_pkg;

	// rectangle plane select
	typedef enum logic [1:0] {
		PLANE_XY     = 2'd0,
		PLANE_XZ     = 2'd1,
		PLANE_YZ     = 2'd2,
		PLANE_UNUSED = 2'd3
	} plane_t;

	// normal axis codes
	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	// register indexes (byte address / 4)
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_PLANE_AXIS   = 3'd0;
	localparam reg_idx_t REG_PLANE_OFFSET = 3'd1;
	localparam reg_idx_t REG_EDGE_A_LOW   = 3'd2;
	localparam reg_idx_t REG_EDGE_A_HIGH  = 3'd3;
	localparam reg_idx_t REG_EDGE_B_LOW   = 3'd4;
	localparam reg_idx_t REG_EDGE_B_HIGH  = 3'd5;
	localparam reg_idx_t REG_MATERIAL_ID  = 3'd6;

	// side data riding along the t divider
	typedef struct packed {
		logic signed [31:0] org_x;
		logic signed [31:0] org_y;
		logic signed [31:0] org_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] t_lo;
		logic signed [31:0] t_hi;
		logic               qneg;
		logic               miss;
	} t_pay_t;

	// side data riding along the texture fraction divider
	typedef struct packed {
		logic [31:0] t;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		axis_t       normal;
		logic        zero_a;
		logic        miss;
	} f_pay_t;

endpackage

`default_nettype wire

### rtl/arh_div_pipe.sv
// ----------------------------------------------------------------------------
// arh_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Caller guarantees rem_in < divisor, so the quotient fits QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_div_pipe #(
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [DW-1:0] rem_in,
	input  logic [DW-1:0] divisor,
	input  logic [QW-1:0] num_lo,
	input  logic [PW-1:0] pay_in,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic [PW-1:0] pay_out
);

	logic [DW-1:0] rem_sk [QW];
	logic [DW-1:0] div_sk [QW];
	logic [QW-1:0] lo_sk  [QW];
	logic [QW-1:0] quo_sk [QW];
	logic [PW-1:0] pay_sk [QW];
	logic          val_sk [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] r_i;
		logic [DW-1:0] d_i;
		logic [QW-1:0] l_i;
		logic [QW-1:0] q_i;
		logic [PW-1:0] p_i;
		logic          v_i;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_i = rem_in;
			assign d_i = divisor;
			assign l_i = num_lo;
			assign q_i = '0;
			assign p_i = pay_in;
			assign v_i = in_valid;
		end else begin : g_next
			assign r_i = rem_sk[k-1];
			assign d_i = div_sk[k-1];
			assign l_i = lo_sk[k-1];
			assign q_i = quo_sk[k-1];
			assign p_i = pay_sk[k-1];
			assign v_i = val_sk[k-1];
		end

		assign trial = {r_i, l_i[QW-1]};
		assign ge    = trial >= {1'b0, d_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_sk[k] <= 1'b0;
			end else if (ce) begin
				val_sk[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_sk[k] <= ge ? DW'(trial - {1'b0, d_i}) : DW'(trial);
				div_sk[k] <= d_i;
				lo_sk[k]  <= {l_i[QW-2:0], 1'b0};
				quo_sk[k] <= {q_i[QW-2:0], ge};
				pay_sk[k] <= p_i;
			end
		end
	end

	assign out_valid = val_sk[QW-1];
	assign quot      = quo_sk[QW-1];
	assign pay_out   = pay_sk[QW-1];

endmodule

`default_nettype wire

### rtl/axis_rect_ray_hit_unit.sv
// ----------------------------------------------------------------------------
// axis_rect_ray_hit_unit
// Ray versus axis-aligned rectangle test in signed fixed point.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         req_valid / req_stall     origin, dir, t window
//  response  out        rsp_valid / rsp_stall     hit, t, u, v, point, normal
//  config    in         APB psel/penable/pwrite   7 registers at 4*i
//
//  One request per cycle while req_stall is low, one response per request, in order.
//  Pipe: input register, 32-stage t divider, window check, multiply,
//  point add, (FRAC_BITS+1)-stage u/v divider and the output register.
//  The whole pipe freezes while a response is held by rsp_stall; req_stall
//  is raised for exactly those cycles.
//  Reset clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_rect_ray_hit_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] t_lower,
	input  logic signed [31:0] t_upper,
	// response
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               hit,
	output logic signed [31:0] hit_t,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic [1:0]         normal_axis,
	output logic [7:0]         hit_material
);
	import arh_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int QF = F + 1;                   // fraction quotient bits
	localparam int UW = (QF > 17) ? QF : 17;     // u/v working width

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647)       r = 32'h7fffffff;
		else if (x < -64'sd2147483648) r = 32'h80000000;
		else                           r = x[31:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// config registers
	// ------------------------------------------------------------------
	plane_t             plane_q;
	logic signed [31:0] offset_q;
	logic signed [31:0] a_low_q;
	logic signed [31:0] a_high_q;
	logic signed [31:0] b_low_q;
	logic signed [31:0] b_high_q;
	logic [7:0]         material_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q    <= PLANE_XY;
			offset_q   <= '0;
			a_low_q    <= '0;
			a_high_q   <= 32'sd1 <<< F;
			b_low_q    <= '0;
			b_high_q   <= 32'sd1 <<< F;
			material_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PLANE_AXIS:   plane_q    <= plane_t'(pwdata[1:0]);
				REG_PLANE_OFFSET: offset_q   <= pwdata;
				REG_EDGE_A_LOW:   a_low_q    <= pwdata;
				REG_EDGE_A_HIGH:  a_high_q   <= pwdata;
				REG_EDGE_B_LOW:   b_low_q    <= pwdata;
				REG_EDGE_B_HIGH:  b_high_q   <= pwdata;
				REG_MATERIAL_ID:  material_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PLANE_AXIS:   prdata = {30'd0, plane_q};
			REG_PLANE_OFFSET: prdata = offset_q;
			REG_EDGE_A_LOW:   prdata = a_low_q;
			REG_EDGE_A_HIGH:  prdata = a_high_q;
			REG_EDGE_B_LOW:   prdata = b_low_q;
			REG_EDGE_B_HIGH:  prdata = b_high_q;
			REG_MATERIAL_ID:  prdata = {24'd0, material_q};
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipe control: global freeze while the response is held
	// ------------------------------------------------------------------
	logic ce;
	logic rsp_valid_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign ce        = !req_stall;

	// ------------------------------------------------------------------
	// stage 1: input register
	// ------------------------------------------------------------------
	logic               v_s1;
	logic signed [31:0] org_x_s1, org_y_s1, org_z_s1;
	logic signed [31:0] dir_x_s1, dir_y_s1, dir_z_s1;
	logic signed [31:0] t_lo_s1, t_hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ce) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			org_x_s1 <= origin_x;
			org_y_s1 <= origin_y;
			org_z_s1 <= origin_z;
			dir_x_s1 <= dir_x;
			dir_y_s1 <= dir_y;
			dir_z_s1 <= dir_z;
			t_lo_s1  <= t_lower;
			t_hi_s1  <= t_upper;
		end
	end

	// t = ((offset - org_n) << F) / dir_n, worked on magnitudes.
	// Quotients of 2^32 or more can never land in a 32-bit window: flag them.
	logic signed [31:0] org_n, dir_n;
	logic               axis_bad;
	logic signed [32:0] diff_n;
	logic [32:0]        mag_n;
	logic [31:0]        dmag_n;
	logic [32+F:0]      num_w;
	logic [31:0]        rem0;
	logic               t_ovf;
	t_pay_t             tpay_in;

	always_comb begin
		axis_bad = 1'b0;
		unique case (plane_q)
			PLANE_XY: begin org_n = org_z_s1; dir_n = dir_z_s1; end
			PLANE_XZ: begin org_n = org_y_s1; dir_n = dir_y_s1; end
			PLANE_YZ: begin org_n = org_x_s1; dir_n = dir_x_s1; end
			default:  begin org_n = org_z_s1; dir_n = dir_z_s1; axis_bad = 1'b1; end
		endcase
	end

	assign diff_n = {offset_q[31], offset_q} - {org_n[31], org_n};
	assign mag_n  = diff_n[32] ? 33'(-diff_n) : diff_n;
	assign dmag_n = dir_n[31] ? 32'(-dir_n) : dir_n;
	assign num_w  = {mag_n, {F{1'b0}}};
	assign rem0   = 32'(num_w >> 32);
	assign t_ovf  = rem0 >= dmag_n;

	always_comb begin
		tpay_in.org_x = org_x_s1;
		tpay_in.org_y = org_y_s1;
		tpay_in.org_z = org_z_s1;
		tpay_in.dir_x = dir_x_s1;
		tpay_in.dir_y = dir_y_s1;
		tpay_in.dir_z = dir_z_s1;
		tpay_in.t_lo  = t_lo_s1;
		tpay_in.t_hi  = t_hi_s1;
		tpay_in.qneg  = diff_n[32] ^ dir_n[31];
		tpay_in.miss  = axis_bad || (dir_n == 32'sd0) || t_ovf;
	end

	// ------------------------------------------------------------------
	// t divider, 32 stages
	// ------------------------------------------------------------------
	logic        tdiv_v;
	logic [31:0] tdiv_q;
	t_pay_t      tdiv_p;

	arh_div_pipe #(
		.DW (32),
		.QW (32),
		.PW ($bits(t_pay_t))
	) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s1),
		.rem_in    (rem0),
		.divisor   (dmag_n),
		.num_lo    (num_w[31:0]),
		.pay_in    (tpay_in),
		.out_valid (tdiv_v),
		.quot      (tdiv_q),
		.pay_out   (tdiv_p)
	);

	// ------------------------------------------------------------------
	// stage 2: sign and window check
	// ------------------------------------------------------------------
	logic signed [33:0] t34;
	logic               win_bad;
	t_pay_t             tpay_w;
	logic               v_s2;
	logic signed [31:0] t_s2;
	t_pay_t             pay_s2;

	assign t34     = tdiv_p.qneg ? -$signed({2'b00, tdiv_q}) : $signed({2'b00, tdiv_q});
	assign win_bad = (t34 < 34'(tdiv_p.t_lo)) || (t34 > 34'(tdiv_p.t_hi));

	always_comb begin
		tpay_w      = tdiv_p;
		tpay_w.miss = tdiv_p.miss || win_bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ce) begin
			v_s2 <= tdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			t_s2   <= t34[31:0];
			pay_s2 <= tpay_w;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: t * dir, three 32x32 products
	// ------------------------------------------------------------------
	logic               v_s3;
	logic signed [31:0] t_s3;
	logic signed [63:0] prod_x_s3, prod_y_s3, prod_z_s3;
	t_pay_t             pay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			t_s3      <= t_s2;
			pay_s3    <= pay_s2;
			prod_x_s3 <= t_s2 * pay_s2.dir_x;
			prod_y_s3 <= t_s2 * pay_s2.dir_y;
			prod_z_s3 <= t_s2 * pay_s2.dir_z;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: hit point = origin + floor(product / 2^F)
	// ------------------------------------------------------------------
	logic               v_s4;
	logic signed [31:0] t_s4;
	logic               miss_s4;
	logic signed [63:0] p_x_s4, p_y_s4, p_z_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			t_s4    <= t_s3;
			miss_s4 <= pay_s3.miss;
			p_x_s4  <= 64'(pay_s3.org_x) + (prod_x_s3 >>> F);
			p_y_s4  <= 64'(pay_s3.org_y) + (prod_y_s3 >>> F);
			p_z_s4  <= 64'(pay_s3.org_z) + (prod_z_s3 >>> F);
		end
	end

	// bounds test and fraction divider setup
	logic signed [63:0] c_a, c_b;
	axis_t              normal_n;
	logic               in_bounds;
	logic signed [32:0] span_a, span_b;
	logic [32:0]        cd_a, cd_b;
	logic               zero_a, zero_b;
	f_pay_t             fpay_in;

	always_comb begin
		unique case (plane_q)
			PLANE_XY: begin c_a = p_x_s4; c_b = p_y_s4; normal_n = AXIS_Z; end
			PLANE_XZ: begin c_a = p_x_s4; c_b = p_z_s4; normal_n = AXIS_Y; end
			PLANE_YZ: begin c_a = p_y_s4; c_b = p_z_s4; normal_n = AXIS_X; end
			default:  begin c_a = p_x_s4; c_b = p_y_s4; normal_n = AXIS_Z; end
		endcase
	end

	assign in_bounds = !((c_a < 64'(a_low_q)) || (c_a > 64'(a_high_q)) ||
	                     (c_b < 64'(b_low_q)) || (c_b > 64'(b_high_q)));
	assign span_a = {a_high_q[31], a_high_q} - {a_low_q[31], a_low_q};
	assign span_b = {b_high_q[31], b_high_q} - {b_low_q[31], b_low_q};
	assign cd_a   = c_a[32:0] - {a_low_q[31], a_low_q};
	assign cd_b   = c_b[32:0] - {b_low_q[31], b_low_q};
	assign zero_a = !(span_a > 33'sd0);
	assign zero_b = !(span_b > 33'sd0);

	always_comb begin
		fpay_in.t      = t_s4;
		fpay_in.px     = sat32(p_x_s4);
		fpay_in.py     = sat32(p_y_s4);
		fpay_in.pz     = sat32(p_z_s4);
		fpay_in.normal = normal_n;
		fpay_in.zero_a = zero_a;
		fpay_in.miss   = miss_s4 || !in_bounds;
	end

	// ------------------------------------------------------------------
	// fraction dividers, FRAC_BITS+1 stages each
	// ------------------------------------------------------------------
	logic          fa_v, fb_v;
	logic [QF-1:0] fa_q, fb_q;
	f_pay_t        fa_p;
	logic          fb_zero;

	arh_div_pipe #(
		.DW (33),
		.QW (QF),
		.PW ($bits(f_pay_t))
	) u_fdiv_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s4),
		.rem_in    (cd_a >> 1),
		.divisor   (span_a),
		.num_lo    ({cd_a[0], {F{1'b0}}}),
		.pay_in    (fpay_in),
		.out_valid (fa_v),
		.quot      (fa_q),
		.pay_out   (fa_p)
	);

	arh_div_pipe #(
		.DW (33),
		.QW (QF),
		.PW (1)
	) u_fdiv_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s4),
		.rem_in    (cd_b >> 1),
		.divisor   (span_b),
		.num_lo    ({cd_b[0], {F{1'b0}}}),
		.pay_in    (zero_b),
		.out_valid (fb_v),
		.quot      (fb_q),
		.pay_out   (fb_zero)
	);

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic [UW-1:0]      frac_a, frac_b, u_w, v_w;
	logic               hit_q;
	logic signed [31:0] hit_t_q, px_q, py_q, pz_q;
	logic [16:0]        tex_u_q, tex_v_q;
	axis_t              normal_q;
	logic [7:0]         mat_q;

	assign frac_a = fa_p.zero_a ? '0 : UW'(fa_q);
	assign frac_b = fb_zero     ? '0 : UW'(fb_q);

	always_comb begin
		if (fa_p.normal == AXIS_X) begin
			// YZ plane: u runs opposite to z
			v_w = frac_a;
			u_w = (UW'(1) << F) - frac_b;
		end else begin
			u_w = frac_a;
			v_w = frac_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ce) begin
			rsp_valid_q <= fa_v && fb_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (fa_p.miss) begin
				hit_q    <= 1'b0;
				hit_t_q  <= '0;
				tex_u_q  <= '0;
				tex_v_q  <= '0;
				px_q     <= '0;
				py_q     <= '0;
				pz_q     <= '0;
				normal_q <= AXIS_X;
				mat_q    <= '0;
			end else begin
				hit_q    <= 1'b1;
				hit_t_q  <= fa_p.t;
				tex_u_q  <= u_w[16:0];
				tex_v_q  <= v_w[16:0];
				px_q     <= fa_p.px;
				py_q     <= fa_p.py;
				pz_q     <= fa_p.pz;
				normal_q <= fa_p.normal;
				mat_q    <= material_q;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign hit_t        = hit_t_q;
	assign tex_u        = tex_u_q;
	assign tex_v        = tex_v_q;
	assign point_x      = px_q;
	assign point_y      = py_q;
	assign point_z      = pz_q;
	assign normal_axis  = normal_q;
	assign hit_material = mat_q;

endmodule

`default_nettype wire

### rtl/arh_check.sv
// ----------------------------------------------------------------------------
// arh_check
// Port-level checks for the ray / rectangle hit unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module arh_check (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        hit,
	input logic [31:0] hit_t,
	input logic [16:0] tex_u,
	input logic [16:0] tex_v,
	input logic [1:0]  normal_axis,
	input logic [7:0]  hit_material
);

	// held response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// requests are pushed back only while a response is held
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a held response");

	// a miss carries zero t, u, v, normal axis and material
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> (hit_t == 32'd0) && (tex_u == 17'd0) &&
		(tex_v == 17'd0) && (normal_axis == 2'd0) && (hit_material == 8'd0))
		else $error("miss with nonzero fields");

	// a hit names a real axis
	a_hit_axis: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> (normal_axis != 2'd3))
		else $error("hit with invalid normal axis");

	// while a request is stalled, the held response stays up
	a_req_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> rsp_valid)
		else $error("response vanished while request side stalled");

endmodule

bind axis_rect_ray_hit_unit arh_check u_arh_check (.*);

`default_nettype wire
